// ----- sv/rrps_pkg.sv -----
// Shared types and constants for the round-robin process scheduler.
// Used by rrps_link_ram, rrps_state_file and round_robin_process_scheduler_unit.
package rrps_pkg;

  // Process ids, link entries and the quantum register are four bits wide.
  localparam int unsigned ID_W = 4;
  localparam int unsigned QUANT_W = 4;
  localparam logic [QUANT_W-1:0] QUANT_RESET = 4'd1;
  localparam logic [QUANT_W-1:0] TICK_MAX = 4'hF;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_MOVE   = 3'd3,
    OP_SET    = 3'd4,
    OP_LEAVE  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    PS_READY    = 2'd0,
    PS_RUNNING  = 2'd1,
    PS_WAITING  = 2'd2,
    PS_FINISHED = 2'd3
  } pstate_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_RUN = 2'd1,
    STAT_BAD_ID = 2'd2
  } stat_e;

  // Write command for the successor link memory.
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] addr;
    logic [ID_W-1:0] data;
  } lk_wr_t;

  // Write command for the per-process state array.
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] id;
    pstate_e         val;
  } st_wr_t;

  // Set or clear command for the ring membership bits.
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] id;
    logic            set;
  } ring_wr_t;

  function automatic logic is_runnable(pstate_e s);
    return (s == PS_READY) || (s == PS_RUNNING);
  endfunction

endpackage

// ----- sv/rrps_link_ram.sv -----
// Successor link memory: one write port, one read port with registered data.
// Depends on rrps_pkg for the id width and the write command struct.
module rrps_link_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  rrps_pkg::lk_wr_t      wr_i,
  input  logic [rrps_pkg::ID_W-1:0] raddr_i,
  output logic [rrps_pkg::ID_W-1:0] rdata_o
);
  import rrps_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ID_W-1:0] mem_q [DEPTH];
  logic [ID_W-1:0] rdata_q;

  // Contents are undefined until written.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[AW'(wr_i.addr)] <= wr_i.data;
    end
    rdata_q <= mem_q[AW'(raddr_i)];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rrps_state_file.sv -----
// Per-process state and ring membership bits, cleared by reset.
// Depends on rrps_pkg for the state enum and the write command structs.
module rrps_state_file #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rrps_pkg::st_wr_t          st_wr_i,
  input  logic [rrps_pkg::ID_W-1:0] st_raddr_i,
  output rrps_pkg::pstate_e         st_rdata_o,
  input  rrps_pkg::ring_wr_t        ring_wr_i,
  input  logic [rrps_pkg::ID_W-1:0] ring_raddr_i,
  output logic                      member_o
);
  import rrps_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pstate_e     state_q [DEPTH];
  logic [DEPTH-1:0] ring_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        state_q[i] <= PS_READY;
      end
      ring_q <= '0;
    end else begin
      if (st_wr_i.we) begin
        state_q[AW'(st_wr_i.id)] <= st_wr_i.val;
      end
      if (ring_wr_i.we) begin
        ring_q[AW'(ring_wr_i.id)] <= ring_wr_i.set;
      end
    end
  end

  assign st_rdata_o = state_q[AW'(st_raddr_i)];

  // An id beyond the table is never a member.
  assign member_o = (int'(ring_raddr_i) < DEPTH) && ring_q[AW'(ring_raddr_i)];

endmodule

// ----- sv/round_robin_process_scheduler_unit.sv -----
// Round-robin process scheduler with a time quantum: sequencer and top level.
// A plain tick or a one-step operation goes from dispatch straight to the response state;
// a rotating tick walks the ring one link per cycle, up to MAX_PROCESSES links; remove and move
// search for the predecessor one link per cycle, up to MAX_PROCESSES links.
// The single read port of the link memory forces these walks; one item is in flight at a time.
// Reset clears membership, process states and control; the link memory is not cleared.
module round_robin_process_scheduler_unit #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,      // quantum_ticks
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [3:0] process_id, [5:4] new_state, [7:6] zero
  input  logic [2:0] s_axis_tuser_i,   // [2:0] operation
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [3:0] current_id, [4] current_valid,
                                       // [5] switched, [7:6] status
);
  import rrps_pkg::*;

  localparam int unsigned CW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_PROCESSES - 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DISP = 13'b0000000000010,
    S_WALK = 13'b0000000000100,
    S_TFIN = 13'b0000000001000,
    S_ADD2 = 13'b0000000010000,
    S_ADD3 = 13'b0000000100000,
    S_REM1 = 13'b0000001000000,
    S_MV1  = 13'b0000010000000,
    S_FIND = 13'b0000100000000,
    S_LNK  = 13'b0001000000000,
    S_MVB  = 13'b0010000000000,
    S_MVC  = 13'b0100000000000,
    S_RESP = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [ID_W-1:0]    cur_q, cur_d;
  logic               ne_q, ne_d;
  logic [QUANT_W-1:0] tick_q, tick_d;
  logic [QUANT_W-1:0] quant_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               old_run_q, old_run_d;
  stat_e              status_q, status_d;
  logic               sw_q, sw_d;

  logic [2:0]      op_q, op_d;
  logic [ID_W-1:0] id_q, id_d;
  pstate_e         ns_q, ns_d;
  logic [ID_W-1:0] ptr_q, ptr_d;
  logic [ID_W-1:0] nxt_q, nxt_d;

  logic            m_valid_q;
  logic [7:0]      m_data_q;
  logic            ld_out;

  lk_wr_t          lk_wr;
  logic [ID_W-1:0] lk_raddr;
  logic [ID_W-1:0] lk_rdata;
  st_wr_t          st_wr;
  logic [ID_W-1:0] st_raddr;
  pstate_e         st_rdata;
  ring_wr_t        ring_wr;
  logic            member;
  logic            id_ok;

  rrps_link_ram #(
    .DEPTH(MAX_PROCESSES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .wr_i   (lk_wr),
    .raddr_i(lk_raddr),
    .rdata_o(lk_rdata)
  );

  rrps_state_file #(
    .DEPTH(MAX_PROCESSES)
  ) u_state_file (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_wr_i     (st_wr),
    .st_raddr_i  (st_raddr),
    .st_rdata_o  (st_rdata),
    .ring_wr_i   (ring_wr),
    .ring_raddr_i(id_q),
    .member_o    (member)
  );

  assign id_ok = int'(id_q) < MAX_PROCESSES;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    ne_d      = ne_q;
    tick_d    = tick_q;
    cnt_d     = cnt_q;
    old_run_d = old_run_q;
    status_d  = status_q;
    sw_d      = sw_q;
    op_d      = op_q;
    id_d      = id_q;
    ns_d      = ns_q;
    ptr_d     = ptr_q;
    nxt_d     = nxt_q;
    ld_out    = 1'b0;
    lk_raddr  = cur_q;
    lk_wr     = '0;
    st_raddr  = cur_q;
    st_wr     = '0;
    ring_wr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = s_axis_tuser_i;
          id_d     = s_axis_tdata_i[3:0];
          ns_d     = pstate_e'(s_axis_tdata_i[5:4]);
          status_d = STAT_OK;
          sw_d     = 1'b0;
          state_d  = S_DISP;
        end
      end

      S_DISP: begin
        state_d = S_RESP;
        unique case (op_e'(op_q))
          OP_TICK: begin
            if (!ne_q) begin
              status_d = STAT_NO_RUN;
            end else if ((tick_q > quant_q) || !is_runnable(st_rdata)) begin
              // Rotate: walk the ring from the current entry, one link per cycle.
              tick_d    = '0;
              old_run_d = is_runnable(st_rdata);
              ptr_d     = cur_q;
              cnt_d     = '0;
              state_d   = S_WALK;
            end else begin
              if (tick_q != TICK_MAX) begin
                tick_d = tick_q + QUANT_W'(1);
              end
              st_wr = '{we: 1'b1, id: cur_q, val: PS_RUNNING};
            end
          end
          OP_ADD: begin
            if (!id_ok || member) begin
              status_d = STAT_BAD_ID;
            end else if (!ne_q) begin
              cur_d   = id_q;
              ne_d    = 1'b1;
              lk_wr   = '{we: 1'b1, addr: id_q, data: id_q};
              ring_wr = '{we: 1'b1, id: id_q, set: 1'b1};
              st_wr   = '{we: 1'b1, id: id_q, val: PS_READY};
            end else begin
              state_d = S_ADD2;
            end
          end
          OP_REMOVE: begin
            if (!member || !ne_q) begin
              status_d = STAT_BAD_ID;
            end else begin
              state_d = S_REM1;
            end
          end
          OP_MOVE: begin
            if (!member || !ne_q) begin
              status_d = STAT_BAD_ID;
            end else if (id_q != cur_q) begin
              state_d = S_MV1;
            end
          end
          OP_SET: begin
            if (!member) begin
              status_d = STAT_BAD_ID;
            end else begin
              st_wr = '{we: 1'b1, id: id_q, val: ns_q};
            end
          end
          OP_LEAVE: begin
            if (ne_q && is_runnable(st_rdata)) begin
              st_wr = '{we: 1'b1, id: cur_q, val: PS_READY};
            end
          end
          default: ;
        endcase
      end

      S_WALK: begin
        // The link just read is the candidate; its state is looked up in the same cycle.
        st_raddr = lk_rdata;
        lk_raddr = lk_rdata;
        if (is_runnable(st_rdata)) begin
          if (old_run_q) begin
            st_wr = '{we: 1'b1, id: cur_q, val: PS_READY};
          end
          sw_d    = (lk_rdata != cur_q);
          cur_d   = lk_rdata;
          state_d = S_TFIN;
        end else if (cnt_q == CNT_LAST) begin
          status_d = STAT_NO_RUN;
          state_d  = S_RESP;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      S_TFIN: begin
        st_wr   = '{we: 1'b1, id: cur_q, val: PS_RUNNING};
        state_d = S_RESP;
      end

      S_ADD2: begin
        lk_wr   = '{we: 1'b1, addr: id_q, data: lk_rdata};
        ring_wr = '{we: 1'b1, id: id_q, set: 1'b1};
        st_wr   = '{we: 1'b1, id: id_q, val: PS_READY};
        state_d = S_ADD3;
      end

      S_ADD3: begin
        lk_wr   = '{we: 1'b1, addr: cur_q, data: id_q};
        state_d = S_RESP;
      end

      S_REM1: begin
        if (lk_rdata == cur_q) begin
          // The only member leaves and the ring becomes empty.
          ring_wr = '{we: 1'b1, id: id_q, set: 1'b0};
          ne_d    = 1'b0;
          cur_d   = '0;
          state_d = S_RESP;
        end else begin
          ptr_d   = cur_q;
          cnt_d   = '0;
          state_d = S_FIND;
        end
      end

      S_MV1: begin
        if (lk_rdata == id_q) begin
          state_d = S_RESP;
        end else begin
          nxt_d   = lk_rdata;
          ptr_d   = cur_q;
          cnt_d   = '0;
          state_d = S_FIND;
        end
      end

      S_FIND: begin
        // Predecessor search: ptr_q is the entry whose successor was just read.
        if (lk_rdata == id_q) begin
          lk_raddr = id_q;
          state_d  = S_LNK;
        end else if (cnt_q == CNT_LAST) begin
          status_d = STAT_BAD_ID;
          state_d  = S_RESP;
        end else begin
          lk_raddr = lk_rdata;
          ptr_d    = lk_rdata;
          cnt_d    = cnt_q + CW'(1);
        end
      end

      S_LNK: begin
        lk_wr = '{we: 1'b1, addr: ptr_q, data: lk_rdata};
        if (op_e'(op_q) == OP_REMOVE) begin
          ring_wr = '{we: 1'b1, id: id_q, set: 1'b0};
          if (cur_q == id_q) begin
            cur_d  = lk_rdata;
            tick_d = '0;
          end
          state_d = S_RESP;
        end else begin
          state_d = S_MVB;
        end
      end

      S_MVB: begin
        lk_wr   = '{we: 1'b1, addr: id_q, data: nxt_q};
        state_d = S_MVC;
      end

      S_MVC: begin
        lk_wr   = '{we: 1'b1, addr: cur_q, data: id_q};
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          ld_out  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '0;
      ne_q      <= 1'b0;
      tick_q    <= '0;
      quant_q   <= QUANT_RESET;
      cnt_q     <= '0;
      old_run_q <= 1'b0;
      status_q  <= STAT_OK;
      sw_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      ne_q      <= ne_d;
      tick_q    <= tick_d;
      cnt_q     <= cnt_d;
      old_run_q <= old_run_d;
      status_q  <= status_d;
      sw_q      <= sw_d;
      if (cfg_we_i) begin
        quant_q <= cfg_wdata_i;
      end
      if (ld_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    id_q  <= id_d;
    ns_q  <= ns_d;
    ptr_q <= ptr_d;
    nxt_q <= nxt_d;
    if (ld_out) begin
      m_data_q <= {status_q, sw_q, ne_q, (ne_q ? cur_q : {ID_W{1'b0}})};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_accept_dispatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == S_DISP))
    else $error("accepted beat did not reach dispatch");

  a_empty_id_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[4]) |-> (m_axis_tdata_o[3:0] == 4'd0))
    else $error("empty ring reported a nonzero current id");

  a_switch_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[5]) |->
      (m_axis_tdata_o[7:6] == STAT_OK) && m_axis_tdata_o[4])
    else $error("switch reported with an error status or an empty ring");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for round_robin_process_scheduler_unit.
// It drives scheduler operations on the input stream, predicts every result beat with its own
// ring model and checks it. Depends on rrps_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module testbench;
  import rrps_pkg::*;

  localparam int unsigned NPROC = 16;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] pid;
    logic [1:0] ns;
  } sched_cmd_t;

  typedef struct packed {
    logic [3:0] cur_id;
    logic       cur_valid;
    logic       switched;
    logic [1:0] status;
  } sched_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [2:0] s_op = '0;
  logic [3:0] s_pid = '0;
  logic [1:0] s_ns = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  // Scheduler model state.
  logic [3:0] succ_link [NPROC];
  pstate_e    proc_st [NPROC];
  logic       member [NPROC];
  logic [3:0] cur_slot;
  logic       ring_busy;
  logic [3:0] tick_cnt;
  logic [3:0] quantum;

  sched_cmd_t pending_cmds [$];
  sched_out_t outcome_q [$];
  int         src_idle_pct = 0;
  int         dst_idle_pct = 0;
  int         errors = 0;
  bit         in_fire = 1'b0;

  always #2 clk_i = ~clk_i;

  round_robin_process_scheduler_unit #(
    .MAX_PROCESSES(NPROC)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i ({2'b00, s_ns, s_pid}),
    .s_axis_tuser_i (s_op),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  function automatic logic can_run(logic [3:0] id);
    return (proc_st[id] == PS_READY) || (proc_st[id] == PS_RUNNING);
  endfunction

  // Entry whose successor is id, or NPROC when the walk from the current entry misses it.
  function automatic int pred_of(logic [3:0] id);
    logic [3:0] p;
    int hit;
    p = cur_slot;
    hit = NPROC;
    for (int i = 0; i < NPROC; i++) begin
      if (hit == NPROC && succ_link[p] == id) hit = int'(p);
      p = succ_link[p];
    end
    return hit;
  endfunction

  function automatic sched_out_t next_schedule(sched_cmd_t cmd);
    sched_out_t res;
    logic [3:0] old;
    logic [3:0] p;
    logic [3:0] c;
    logic found;
    int pr;
    res = '0;
    res.status = STAT_OK;
    case (cmd.op)
      OP_TICK: begin
        if (!ring_busy) begin
          res.status = STAT_NO_RUN;
        end else begin
          old = cur_slot;
          if (tick_cnt > quantum || !can_run(old)) begin
            tick_cnt = '0;
            p = old;
            found = 1'b0;
            for (int i = 0; i < NPROC; i++) begin
              if (!found) begin
                p = succ_link[p];
                found = can_run(p);
              end
            end
            if (found) begin
              if (can_run(old)) proc_st[old] = PS_READY;
              cur_slot = p;
              proc_st[p] = PS_RUNNING;
              res.switched = (p != old);
            end else begin
              res.status = STAT_NO_RUN;
            end
          end else begin
            if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 4'd1;
            proc_st[old] = PS_RUNNING;
          end
        end
      end
      OP_ADD: begin
        if (member[cmd.pid]) begin
          res.status = STAT_BAD_ID;
        end else begin
          if (!ring_busy) begin
            cur_slot = cmd.pid;
            succ_link[cmd.pid] = cmd.pid;
            ring_busy = 1'b1;
          end else begin
            succ_link[cmd.pid] = succ_link[cur_slot];
            succ_link[cur_slot] = cmd.pid;
          end
          member[cmd.pid] = 1'b1;
          proc_st[cmd.pid] = PS_READY;
        end
      end
      OP_REMOVE: begin
        if (!member[cmd.pid] || !ring_busy) begin
          res.status = STAT_BAD_ID;
        end else if (succ_link[cur_slot] == cur_slot) begin
          member[cmd.pid] = 1'b0;
          ring_busy = 1'b0;
          cur_slot = '0;
        end else begin
          pr = pred_of(cmd.pid);
          if (pr >= NPROC) begin
            res.status = STAT_BAD_ID;
          end else begin
            succ_link[pr[3:0]] = succ_link[cmd.pid];
            member[cmd.pid] = 1'b0;
            if (cur_slot == cmd.pid) begin
              cur_slot = succ_link[cmd.pid];
              tick_cnt = '0;
            end
          end
        end
      end
      OP_MOVE: begin
        if (!member[cmd.pid] || !ring_busy) begin
          res.status = STAT_BAD_ID;
        end else if (cmd.pid != cur_slot && succ_link[cur_slot] != cmd.pid) begin
          pr = pred_of(cmd.pid);
          if (pr >= NPROC) begin
            res.status = STAT_BAD_ID;
          end else begin
            c = cur_slot;
            succ_link[pr[3:0]] = succ_link[cmd.pid];
            succ_link[cmd.pid] = succ_link[c];
            succ_link[c] = cmd.pid;
          end
        end
      end
      OP_SET: begin
        if (!member[cmd.pid]) res.status = STAT_BAD_ID;
        else proc_st[cmd.pid] = pstate_e'(cmd.ns);
      end
      OP_LEAVE: begin
        if (ring_busy && can_run(cur_slot)) proc_st[cur_slot] = PS_READY;
      end
      default: begin
        // Reserved codes still produce an ok result and change nothing.
      end
    endcase
    res.cur_id = ring_busy ? cur_slot : 4'd0;
    res.cur_valid = ring_busy;
    return res;
  endfunction

  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t cmd;
    int w;
    w = $urandom_range(99);
    cmd.pid = 4'($urandom_range(15));
    cmd.ns = 2'($urandom_range(3));
    if (w < 38) cmd.op = OP_TICK;
    else if (w < 54) cmd.op = OP_ADD;
    else if (w < 66) cmd.op = OP_REMOVE;
    else if (w < 76) cmd.op = OP_MOVE;
    else if (w < 90) cmd.op = OP_SET;
    else if (w < 96) cmd.op = OP_LEAVE;
    else cmd.op = ($urandom_range(1) != 0) ? OP_RSVD7 : OP_RSVD6;
    return cmd;
  endfunction

  task automatic push_cmd(logic [2:0] op, logic [3:0] pid, logic [1:0] ns);
    pending_cmds.push_back('{op: op, pid: pid, ns: ns});
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Checked a little after the falling edge, once the driver's updates have settled.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || s_tvalid || outcome_q.size() != 0) begin
      @(negedge clk_i);
      #1;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_quantum(logic [3:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    quantum = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Input driver: a new beat is offered only once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || in_fire) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_op <= pending_cmds[0].op;
          s_pid <= pending_cmds[0].pid;
          s_ns <= pending_cmds[0].ns;
          void'(pending_cmds.pop_front());
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Monitor: results are checked before the beat accepted at the same edge is predicted.
  always @(posedge clk_i) begin
    sched_out_t got;
    sched_out_t want;
    in_fire = s_tvalid && s_tready && rst_ni;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        got.cur_id = m_tdata[3:0];
        got.cur_valid = m_tdata[4];
        got.switched = m_tdata[5];
        got.status = m_tdata[7:6];
        if (outcome_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, tdata", int'(m_tdata), 0);
        end else begin
          want = outcome_q.pop_front();
          if (got.cur_id !== want.cur_id)
            report_mismatch("current_id", int'(got.cur_id), int'(want.cur_id));
          if (got.cur_valid !== want.cur_valid)
            report_mismatch("current_valid", int'(got.cur_valid), int'(want.cur_valid));
          if (got.switched !== want.switched)
            report_mismatch("switched", int'(got.switched), int'(want.switched));
          if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
        end
      end
      if (in_fire) outcome_q.push_back(next_schedule('{op: s_op, pid: s_pid, ns: s_ns}));
    end
  end

  initial begin
    logic [3:0] quanta [6];
    for (int i = 0; i < NPROC; i++) begin
      succ_link[i] = '0;
      proc_st[i] = PS_READY;
      member[i] = 1'b0;
    end
    cur_slot = '0;
    ring_busy = 1'b0;
    tick_cnt = '0;
    quantum = QUANT_RESET;
    quanta = '{4'd0, 4'd15, 4'($urandom_range(2, 14)), 4'd2, 4'($urandom_range(15)), 4'd15};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, run with the reset quantum.
    src_idle_pct = 30;
    dst_idle_pct = 52;
    push_cmd(OP_TICK, 4'd0, 2'd0);       // empty ring
    push_cmd(OP_LEAVE, 4'd0, 2'd0);      // ignored on an empty ring
    push_cmd(OP_REMOVE, 4'd5, 2'd0);
    push_cmd(OP_MOVE, 4'd5, 2'd0);
    push_cmd(OP_SET, 4'd5, PS_RUNNING);
    push_cmd(OP_ADD, 4'd0, 2'd0);        // first member links to itself
    push_cmd(OP_ADD, 4'd0, 2'd0);        // already present
    push_cmd(OP_TICK, 4'd0, 2'd0);
    push_cmd(OP_REMOVE, 4'd0, 2'd0);     // last member empties the ring
    push_cmd(OP_ADD, 4'd15, 2'd0);
    push_cmd(OP_ADD, 4'd0, 2'd0);
    push_cmd(OP_ADD, 4'd7, 2'd0);
    push_cmd(OP_MOVE, 4'd0, 2'd0);       // neither current nor successor
    push_cmd(OP_MOVE, 4'd15, 2'd0);      // current: no change
    push_cmd(OP_MOVE, 4'd0, 2'd0);       // successor: no change
    push_cmd(OP_SET, 4'd7, PS_WAITING);
    push_cmd(OP_SET, 4'd0, PS_FINISHED);
    push_cmd(OP_SET, 4'd15, PS_WAITING);
    push_cmd(OP_TICK, 4'd0, 2'd0);       // nothing runnable
    push_cmd(OP_SET, 4'd7, PS_READY);
    push_cmd(OP_TICK, 4'd0, 2'd0);       // current waiting: switch at once
    push_cmd(OP_SET, 4'd15, PS_RUNNING);
    repeat (4) push_cmd(OP_TICK, 4'd0, 2'd0);  // quantum expiry
    push_cmd(OP_REMOVE, 4'd7, 2'd0);
    push_cmd(OP_LEAVE, 4'd0, 2'd0);
    push_cmd(OP_RSVD6, 4'd15, 2'd3);
    push_cmd(OP_RSVD7, 4'd0, 2'd0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_quantum(quanta[ph]);
      if (ph < 2) begin
        src_idle_pct = 30;
        dst_idle_pct = 52;
      end else if (ph < 4) begin
        src_idle_pct = 52;
        dst_idle_pct = 30;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) pending_cmds.push_back(rand_cmd());
      wait_idle();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
